// ===== hw/rtl/ibpc_pkg.sv =====
// Shared types and constants for the indirect block path calculator.
`default_nettype none

package ibpc_pkg;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_DIRECT  = 2'd0;
  localparam status_t STATUS_PATH    = 2'd1;
  localparam status_t STATUS_TOO_BIG = 2'd2;

  // Configuration register map
  localparam int unsigned ADDR_W       = 3;
  localparam logic        REG_PTR_SHIFT = 1'b0;

  // Pointer shift limits and reset value
  localparam logic [3:0] PTR_SHIFT_MIN   = 4'd1;
  localparam logic [3:0] PTR_SHIFT_MAX   = 4'd11;
  localparam logic [3:0] PTR_SHIFT_RESET = 4'd10;

  // Most results one lookup can produce
  localparam int unsigned MAX_RESULTS = 4;

  // Wide working word: holds capacities up to three levels of 2^11 pointers
  typedef logic [33:0] wide_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indirect_block_path_calc_top.sv =====
// Indirect block path calculator: top level with pipeline and result emitter.
//
// Usage. A lookup transaction is issued by raising start with logical_block set; it
// is taken at a rising edge where start is high and busy is low. Negative numbers
// name metadata blocks. Each lookup gives one to four result transactions, shown
// for exactly one cycle each with result_valid high; last marks the final one and
// level_index counts them from zero. The receiver cannot stall the block.
// Throughput: a lookup passes an input register, a magnitude stage and a level
// stage, then loads the result emitter, which sends one result per cycle. A
// lookup with several results therefore holds the emitter until its last result
// is sent, and later lookups wait in the stages; single-result lookups flow every
// cycle. busy rises only when the three stages are full behind a busy emitter.
// Configuration: ptr_shift is written through the APB port at address 0; the user
// must write it only while no lookup is in flight, which the block does not enforce;
// values of 0 act as 1, values above 11 act as 11. Reset: rst (synchronous) empties
// all stages and the emitter and sets ptr_shift to 10. No memory needs clearing.
`default_nettype none

module indirect_block_path_calc_top #(
  parameter int DIRECT_BLOCKS   = 12,
  parameter int INDIRECT_LEVELS = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Lookup channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [31:0]            logical_block,
  // Result channel
  output logic                               result_valid,
  output ibpc_pkg::status_t                  status,
  output logic signed [31:0]                 meta_block,
  output logic [10:0]                        entry_offset,
  output logic [1:0]                         level_index,
  output logic                               last,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ibpc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import ibpc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [3:0] ptr_shift;
  logic [3:0] s_eff;
  logic [5:0] s_two;
  logic [5:0] s_three;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PTR_SHIFT) ? {28'd0, ptr_shift} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_shift <= PTR_SHIFT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PTR_SHIFT)) begin
      ptr_shift <= pwdata[3:0];
    end
  end

  // Clamp the shift into its legal range.
  always_comb begin
    if (ptr_shift < PTR_SHIFT_MIN) begin
      s_eff = PTR_SHIFT_MIN;
    end else if (ptr_shift > PTR_SHIFT_MAX) begin
      s_eff = PTR_SHIFT_MAX;
    end else begin
      s_eff = ptr_shift;
    end
  end

  assign s_two   = 6'(s_eff) << 1;
  assign s_three = s_two + 6'(s_eff);

  // ---------------------------------------------------------------------------
  // Flow control. Each stage advances when the one after it is empty or moving.
  // ---------------------------------------------------------------------------
  logic       r1_valid, r2_valid, r3_valid, e_valid;
  logic [1:0] e_idx, e_last_idx;
  logic       e_free, r3_free, r2_free, load;

  assign last    = (e_idx == e_last_idx);
  assign e_free  = !e_valid || last;
  assign load    = r3_valid && e_free;
  assign r3_free = !r3_valid || e_free;
  assign r2_free = !r2_valid || r3_free;
  assign busy    = r1_valid && !r2_free;

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [31:0] r1_lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (!busy) begin
      r1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      r1_lb <= logical_block;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitude and distance past the direct blocks
  // ---------------------------------------------------------------------------
  logic [30:0] mag;
  logic        too_neg;
  status_t     s2_status;
  logic [31:0] r2_bn, r2_lb;
  logic [10:0] r2_off_direct;
  status_t     r2_status;

  always_comb begin
    too_neg = (r1_lb == 32'h8000_0000);
    mag     = r1_lb[31] ? 31'(~r1_lb + 32'd1) : r1_lb[30:0];
    if (too_neg) begin
      s2_status = STATUS_TOO_BIG;
    end else if ({1'b0, mag} < 32'(DIRECT_BLOCKS)) begin
      s2_status = STATUS_DIRECT;
    end else begin
      s2_status = STATUS_PATH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (r2_free) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r2_free && r1_valid) begin
      r2_status     <= s2_status;
      r2_bn         <= {1'b0, mag} - 32'(DIRECT_BLOCKS);
      r2_off_direct <= mag[10:0];
      r2_lb         <= r1_lb;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: indirection level, remainder within it and first meta block
  // ---------------------------------------------------------------------------
  wide_t      cap1, cap2, cap3, bn_w, dist1, dist2;
  logic       lt0, lt1, lt2;
  logic [1:0] lvl;
  wide_t      bnk, capsum;
  status_t    s3_status;

  wide_t       r3_bnk, r3_m0;
  logic [1:0]  r3_k;
  status_t     r3_status;
  logic [10:0] r3_off_direct;
  logic [31:0] r3_lb;

  always_comb begin
    cap1   = wide_t'(1) << s_eff;
    cap2   = wide_t'(1) << s_two;
    cap3   = wide_t'(1) << s_three;
    bn_w   = {2'b00, r2_bn};
    dist1  = bn_w - cap1;
    dist2  = bn_w - (cap1 | cap2);
    lt0    = bn_w < cap1;
    lt1    = dist1 < cap2;
    lt2    = dist2 < cap3;
    lvl    = 2'd0;
    bnk    = bn_w;
    capsum = '0;
    s3_status = r2_status;
    if (lt0) begin
      lvl = 2'd0;
    end else if (lt1 && (INDIRECT_LEVELS >= 2)) begin
      lvl    = 2'd1;
      bnk    = dist1;
      capsum = cap1;
    end else if (lt2 && (INDIRECT_LEVELS >= 3)) begin
      lvl    = 2'd2;
      bnk    = dist2;
      capsum = cap1 | cap2;
    end else if (r2_status == STATUS_PATH) begin
      s3_status = STATUS_TOO_BIG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else if (r3_free) begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r3_free && r2_valid) begin
      r3_status     <= s3_status;
      r3_k          <= lvl;
      r3_bnk        <= bnk;
      // The top indirect block is named by the negated number of the first
      // block it covers, less its depth.
      r3_m0         <= wide_t'(0) - (wide_t'(DIRECT_BLOCKS) + wide_t'(lvl) + capsum);
      r3_off_direct <= r2_off_direct;
      r3_lb         <= r2_lb;
    end
  end

  // ---------------------------------------------------------------------------
  // Path entries. Entry 0 names the top meta block and its slot in the inode.
  // Entry i+1 carries meta block i and the slot taken from the remainder.
  // A metadata lookup stops at entry i when meta block i is the target.
  // ---------------------------------------------------------------------------
  wide_t       meta_w [0:2];
  logic [10:0] field  [0:2];
  logic [2:0]  stop;
  wide_t       real_w, hi;
  logic [5:0]  amt_hi, amt_f;
  logic [10:0] omask;
  logic [1:0]  last_next;
  logic [31:0] meta_next [0:MAX_RESULTS-1];
  logic [10:0] off_next  [0:MAX_RESULTS-1];

  always_comb begin
    real_w = {{2{r3_lb[31]}}, r3_lb};
    omask  = (11'd1 << s_eff) - 11'd1;
    for (int i = 0; i < 3; i++) begin
      amt_hi    = 6'(s_eff) * (6'(r3_k) + 6'd1 - 6'(i));
      hi        = r3_bnk & ~((wide_t'(1) << amt_hi) - wide_t'(1));
      meta_w[i] = (i == 0) ? r3_m0 : (r3_m0 + wide_t'(i) - hi);
      amt_f     = 6'(s_eff) * (6'(r3_k) - 6'(i));
      field[i]  = 11'(r3_bnk >> amt_f) & omask;
      stop[i]   = (2'(i) <= r3_k) && (meta_w[i] == real_w);
    end

    last_next = r3_k + 2'd1;
    for (int i = 2; i >= 0; i--) begin
      if (stop[i]) begin
        last_next = 2'(i);
      end
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      meta_next[i] = '0;
      off_next[i]  = '0;
    end

    case (r3_status)
      STATUS_DIRECT: begin
        last_next   = 2'd0;
        off_next[0] = r3_off_direct;
      end
      STATUS_PATH: begin
        meta_next[0] = meta_w[0][31:0];
        off_next[0]  = 11'(r3_k);
        for (int i = 0; i < 3; i++) begin
          meta_next[i+1] = meta_w[i][31:0];
          off_next[i+1]  = field[i];
        end
      end
      default: begin
        last_next = 2'd0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result emitter: one result per cycle from the loaded path.
  // ---------------------------------------------------------------------------
  status_t     e_status;
  logic [31:0] e_meta [0:MAX_RESULTS-1];
  logic [10:0] e_off  [0:MAX_RESULTS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_idx   <= 2'd0;
    end else if (load) begin
      e_valid <= 1'b1;
      e_idx   <= 2'd0;
    end else if (e_valid) begin
      if (last) begin
        e_valid <= 1'b0;
      end else begin
        e_idx <= e_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e_status   <= r3_status;
      e_last_idx <= last_next;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        e_meta[i] <= meta_next[i];
        e_off[i]  <= off_next[i];
      end
    end
  end

  assign result_valid = e_valid;
  assign status       = e_status;
  assign meta_block   = e_meta[e_idx];
  assign entry_offset = e_off[e_idx];
  assign level_index  = e_idx;

`ifndef NO_ASSERTIONS
  // The block only pushes back when a lookup is actually held at its input.
  a_busy_held: assert property (@(posedge clk) disable iff (rst)
    busy |-> r1_valid)
    else $error("busy raised with an empty input register");

  // A result that is not the last is followed at once by the next one.
  a_path_continues: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=>
      (result_valid && (level_index == $past(level_index) + 2'd1)))
    else $error("path results not consecutive");

  // Direct and too-big lookups give a single result.
  a_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != STATUS_PATH)) |-> (last && (level_index == 2'd0)))
    else $error("non-path lookup gave more than one result");

  // The first path entry carries the level, which stays within the indirection depth.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == STATUS_PATH) && (level_index == 2'd0)) |->
      (entry_offset < 11'(INDIRECT_LEVELS)))
    else $error("indirection level out of range");
`endif

endmodule

`default_nettype wire
